FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the cyclic code unit.
// Each macro expands to one labeled concurrent assertion that is
// disabled while reset is high and reports through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// The condition must never be seen at a rising clock edge.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

FILE: src/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// Shared constants, command and state types of the cyclic code encoder and
// single-error corrector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cce_pkg;

   // Code geometry.
   localparam int MAX_LEN    = 31;
   localparam int CHECK_BITS = 5;
   localparam int TAP_W      = 5;
   localparam logic [TAP_W-1:0] TAPS_RESET = 5'd23;

   // Bit counter saturates at its all-ones value.
   localparam int CNT_W  = 6;
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int CHK_W  = $clog2(CHECK_BITS + 1);

   // Command queue between the front and back parts.
   localparam int QDEPTH = 4;
   localparam int QIDX_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      CMD_ENC_BIT  = 2'd0,
      CMD_ENC_LAST = 2'd1,
      CMD_DEC_WORD = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic                    data_bit;
      logic                    failed;
      logic [CHECK_BITS-1:0]   remainder;
      logic [LEN_W-1:0]        len;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_EMIT   = 4'b1000
   } back_state_type;

endpackage

FILE: src/cce_ram.sv
// ----------------------------------------------------------------------------
// cce_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cce_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/cce_queue.sv
// ----------------------------------------------------------------------------
// cce_queue
// Short command queue that decouples request intake from result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cce_queue
   import cce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type head
);

   cmd_type           entry_ff [QDEPTH];
   logic [QIDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QIDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QDEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ASSERT_NEVER(a_queue_no_overflow, clock, reset, push && full && !pop)
   `ASSERT_NEVER(a_queue_no_underflow, clock, reset, pop && !valid)

endmodule

FILE: src/cce_front.sv
// ----------------------------------------------------------------------------
// cce_front
// Request intake: runs the remainder division, stores received bits and
// turns each request into a command for the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cce_front
   import cce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_mode,
   input  logic              req_data_bit,
   input  logic              req_last_in,
   input  logic [TAP_W-1:0]  taps,
   input  logic              q_full,
   output logic              push,
   output cmd_type           push_cmd,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic              wr_data,
   input  logic              word_done
);

   logic [CHECK_BITS-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;
   logic                  hold_ff, hold_in;

   logic                  accept;
   logic [CHECK_BITS-1:0] poly;
   logic                  feedback;
   logic [CHECK_BITS-1:0] enc_rem;
   logic [CHECK_BITS-1:0] dec_rem;
   logic                  enc_ovf;
   logic                  dec_ovf;
   logic                  ovf_new;
   logic [CNT_W-1:0]      cnt_new;
   logic [LEN_W-1:0]      word_len;

   // A decoded word holds off intake until its bits have been read back.
   assign busy   = q_full | hold_ff;
   assign accept = start & ~busy;

   // Division step for both modes.
   always_comb begin
      poly     = CHECK_BITS'(taps);
      feedback = req_data_bit ^ rem_ff[CHECK_BITS-1];
      enc_rem  = (rem_ff << 1) ^ ({CHECK_BITS{feedback}} & poly);
      dec_rem  = ((rem_ff << 1) | CHECK_BITS'(req_data_bit))
                 ^ ({CHECK_BITS{rem_ff[CHECK_BITS-1]}} & poly);
      enc_ovf  = (({1'b0, cnt_ff} + (CNT_W + 1)'(CHECK_BITS)) >= (CNT_W + 1)'(MAX_LEN));
      dec_ovf  = (cnt_ff >= CNT_W'(MAX_LEN));
      ovf_new  = ovf_ff | (req_mode ? dec_ovf : enc_ovf);
      cnt_new  = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
      word_len = (cnt_new >= CNT_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : LEN_W'(cnt_new);
   end

   // Bit store write.
   assign wr_en   = accept & (cnt_ff < CNT_W'(MAX_LEN));
   assign wr_addr = ADDR_W'(cnt_ff);
   assign wr_data = req_data_bit;

   // Command toward the output side.
   always_comb begin
      push               = accept & (~req_mode | req_last_in);
      push_cmd.data_bit  = req_data_bit;
      push_cmd.failed    = ovf_new;
      push_cmd.len       = word_len;
      if (req_mode) begin
         push_cmd.kind      = CMD_DEC_WORD;
         push_cmd.remainder = dec_rem;
      end else begin
         push_cmd.kind      = req_last_in ? CMD_ENC_LAST : CMD_ENC_BIT;
         push_cmd.remainder = enc_rem;
      end
   end

   // Running word state; the final bit returns it to zero.
   always_comb begin
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      hold_in = hold_ff;
      if (accept) begin
         if (req_last_in) begin
            rem_in = '0;
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            rem_in = req_mode ? dec_rem : enc_rem;
            cnt_in = cnt_new;
            ovf_in = ovf_new;
         end
      end
      if (accept && req_mode && req_last_in) begin
         hold_in = 1'b1;
      end else if (word_done) begin
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         hold_ff <= 1'b0;
      end else begin
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         hold_ff <= hold_in;
      end
   end

   `ASSERT_NEVER(a_front_no_write_during_readout, clock, reset, hold_ff && wr_en)
   `ASSERT_ALWAYS(a_front_done_only_when_held, clock, reset, word_done |-> hold_ff)

endmodule

FILE: src/cce_back.sv
// ----------------------------------------------------------------------------
// cce_back
// Output side: emits encoded bits and check bits, runs the single-error
// position search and plays back the corrected word from the bit store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cce_back
   import cce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [TAP_W-1:0]  taps,
   input  logic              q_valid,
   input  cmd_type           q_head,
   output logic              pop,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic              rd_data,
   output logic              word_done,
   output logic              rsp_strobe,
   output logic              rsp_code_bit,
   output logic              rsp_last_out,
   output logic              rsp_corrected,
   output logic              rsp_failed
);

   back_state_type        state_ff, state_in;
   logic [CHECK_BITS-1:0] chk_ff, chk_in;
   logic [CHK_W-1:0]      kcnt_ff, kcnt_in;
   logic                  fail_ff, fail_in;
   logic                  corr_ff, corr_in;
   logic [CHECK_BITS-1:0] syn_ff, syn_in;
   logic [CHECK_BITS-1:0] err_ff, err_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic [ADDR_W-1:0]     lastpos_ff, lastpos_in;
   logic [ADDR_W-1:0]     flip_ff, flip_in;
   logic                  found_ff, found_in;
   logic [ADDR_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                  issue_ff, issue_in;
   logic [ADDR_W-1:0]     issue_idx_ff, issue_idx_in;
   logic                  strobe_ff, strobe_in;
   logic                  bit_ff, bit_in;
   logic                  lo_ff, lo_in;
   logic                  co_ff, co_in;
   logic                  fo_ff, fo_in;

   logic [CHECK_BITS-1:0] poly;
   logic [CHECK_BITS-1:0] err_step;
   logic                  match;
   logic [ADDR_W-1:0]     head_lastpos;

   assign rd_addr = rd_idx_ff;

   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      word_done    = 1'b0;
      chk_in       = chk_ff;
      kcnt_in      = kcnt_ff;
      fail_in      = fail_ff;
      corr_in      = corr_ff;
      syn_in       = syn_ff;
      err_in       = err_ff;
      pos_in       = pos_ff;
      lastpos_in   = lastpos_ff;
      flip_in      = flip_ff;
      found_in     = found_ff;
      rd_idx_in    = rd_idx_ff;
      issue_in     = 1'b0;
      issue_idx_in = issue_idx_ff;
      strobe_in    = 1'b0;
      bit_in       = bit_ff;
      lo_in        = lo_ff;
      co_in        = co_ff;
      fo_in        = fo_ff;

      // Error pattern syndrome for the next lower position: x times the current one.
      poly         = CHECK_BITS'(taps);
      err_step     = (err_ff << 1) ^ ({CHECK_BITS{err_ff[CHECK_BITS-1]}} & poly);
      match        = (err_ff == syn_ff);
      head_lastpos = ADDR_W'(q_head.len - 1'b1);

      // Store read data comes from a registered read port; flip the chosen bit.
      if (issue_ff) begin
         strobe_in = 1'b1;
         bit_in    = rd_data ^ (corr_ff & (issue_idx_ff == flip_ff));
         lo_in     = (issue_idx_ff == lastpos_ff);
         co_in     = corr_ff;
         fo_in     = fail_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            // Wait for the playback stage to drain so results never collide.
            if (q_valid && !issue_ff) begin
               pop = 1'b1;
               case (q_head.kind)
                  CMD_ENC_BIT: begin
                     strobe_in = 1'b1;
                     bit_in    = q_head.data_bit;
                     lo_in     = 1'b0;
                     co_in     = 1'b0;
                     fo_in     = q_head.failed;
                  end
                  CMD_ENC_LAST: begin
                     strobe_in = 1'b1;
                     bit_in    = q_head.data_bit;
                     lo_in     = 1'b0;
                     co_in     = 1'b0;
                     fo_in     = q_head.failed;
                     chk_in    = q_head.remainder;
                     kcnt_in   = CHK_W'(CHECK_BITS - 1);
                     fail_in   = q_head.failed;
                     state_in  = ST_CHECK;
                  end
                  CMD_DEC_WORD: begin
                     lastpos_in = head_lastpos;
                     syn_in     = q_head.remainder;
                     rd_idx_in  = '0;
                     if ((q_head.remainder != '0) && !q_head.failed) begin
                        err_in   = CHECK_BITS'(1);
                        pos_in   = head_lastpos;
                        found_in = 1'b0;
                        state_in = ST_SEARCH;
                     end else begin
                        corr_in  = 1'b0;
                        fail_in  = q_head.failed;
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            // Check bits, most significant first.
            strobe_in = 1'b1;
            bit_in    = chk_ff[CHECK_BITS-1];
            lo_in     = (kcnt_ff == '0);
            co_in     = 1'b0;
            fo_in     = fail_ff;
            chk_in    = chk_ff << 1;
            kcnt_in   = kcnt_ff - 1'b1;
            if (kcnt_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            // Walk from the last position to the first; the earliest match wins.
            if (match) begin
               flip_in  = pos_ff;
               found_in = 1'b1;
            end
            err_in = err_step;
            pos_in = pos_ff - 1'b1;
            if (pos_ff == '0) begin
               corr_in  = found_ff | match;
               fail_in  = ~(found_ff | match);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // One store read per cycle.
            issue_in     = 1'b1;
            issue_idx_in = rd_idx_ff;
            rd_idx_in    = rd_idx_ff + 1'b1;
            if (rd_idx_ff == lastpos_ff) begin
               word_done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issue_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         strobe_ff <= strobe_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      chk_ff       <= chk_in;
      kcnt_ff      <= kcnt_in;
      fail_ff      <= fail_in;
      corr_ff      <= corr_in;
      syn_ff       <= syn_in;
      err_ff       <= err_in;
      pos_ff       <= pos_in;
      lastpos_ff   <= lastpos_in;
      flip_ff      <= flip_in;
      found_ff     <= found_in;
      rd_idx_ff    <= rd_idx_in;
      issue_idx_ff <= issue_idx_in;
      bit_ff       <= bit_in;
      lo_ff        <= lo_in;
      co_ff        <= co_in;
      fo_ff        <= fo_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_code_bit  = bit_ff;
   assign rsp_last_out  = lo_ff;
   assign rsp_corrected = co_ff;
   assign rsp_failed    = fo_ff;

endmodule

FILE: src/cyclic_code_encoder_corrector.sv
// An encoded bit passes through the command queue and the output register; the 5 check bits follow.
// A decoded word passes through the command queue, then a search of one step per position if the
// syndrome is nonzero, then the store reads and the output register, one bit per cycle.
// Throughput: one request per cycle until the 4-entry command queue fills; none from a
// decoded word's final bit until its last store read. Results cannot be held off.
// Reset is synchronous; it clears control state and sets the generator taps to 23.
// ----------------------------------------------------------------------------
// cyclic_code_encoder_corrector
// Bit-serial systematic encoder and single-error corrector for a binary
// cyclic code with a programmable generator polynomial.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cyclic_code_encoder_corrector
   import cce_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_mode,
   input  logic             req_data_bit,
   input  logic             req_last_in,
   output logic             rsp_strobe,
   output logic             rsp_code_bit,
   output logic             rsp_last_out,
   output logic             rsp_corrected,
   output logic             rsp_failed,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TAP_W-1:0] csr_generator_taps
);

   logic [TAP_W-1:0]  taps_ff, taps_in;
   logic              q_full;
   logic              push;
   cmd_type           push_cmd;
   logic              pop;
   logic              q_valid;
   cmd_type           q_head;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_data;
   logic              word_done;

   // Generator register; writes are always taken.
   assign csr_ready = 1'b1;
   assign taps_in   = (csr_valid && csr_ready) ? csr_generator_taps : taps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= TAPS_RESET;
      end else begin
         taps_ff <= taps_in;
      end
   end

   // Request intake and division.
   cce_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_data_bit (req_data_bit),
      .req_last_in  (req_last_in),
      .taps         (taps_ff),
      .q_full       (q_full),
      .push         (push),
      .push_cmd     (push_cmd),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .word_done    (word_done)
   );

   // Command queue.
   cce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   // Received word store.
   cce_ram #(
      .WIDTH (1),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output side.
   cce_back u_back (
      .clock         (clock),
      .reset         (reset),
      .taps          (taps_ff),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .pop           (pop),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .word_done     (word_done),
      .rsp_strobe    (rsp_strobe),
      .rsp_code_bit  (rsp_code_bit),
      .rsp_last_out  (rsp_last_out),
      .rsp_corrected (rsp_corrected),
      .rsp_failed    (rsp_failed)
   );

endmodule

FILE: tb/cce_checker.sv
// ----------------------------------------------------------------------------
// cce_checker
// Watches the request, result and register channels of the cyclic code unit.
// It keeps its own model of the encoder and corrector and compares every
// result bit with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cce_checker
   import cce_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic             req_mode,
   input  logic             req_data_bit,
   input  logic             req_last_in,
   input  logic             rsp_strobe,
   input  logic             rsp_code_bit,
   input  logic             rsp_last_out,
   input  logic             rsp_corrected,
   input  logic             rsp_failed,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [TAP_W-1:0] csr_generator_taps,
   output int               mismatch_count,
   output int               pending_count,
   output int               checked_count,
   output int               corrected_count
);

   // One emitted code bit with its flags.
   typedef struct packed {
      logic code_bit;
      logic last_out;
      logic corrected;
      logic failed;
   } code_bit_type;

   code_bit_type          expected_bits_q[$];

   // Model state.
   logic [TAP_W-1:0]      gen_taps;
   logic                  word_copy[MAX_LEN];
   logic [CHECK_BITS-1:0] syndrome;
   int                    bit_cnt;
   logic                  overrun;

   int                    errors;
   int                    checked;
   int                    corr_seen;

   assign mismatch_count  = errors;
   assign checked_count   = checked;
   assign corrected_count = corr_seen;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task automatic clear_word();
      syndrome = '0;
      bit_cnt  = 0;
      overrun  = 1'b0;
   endtask

   // Step the model by one request and queue the code bits it produces.
   task automatic predict_request(input logic mode, input logic data, input logic last);
      logic                  fb;
      logic [CHECK_BITS:0]   wide;
      logic [CHECK_BITS-1:0] err_syn;
      int                    len;
      int                    flip;
      logic                  corr;
      logic                  fail;
      code_bit_type          item;
      if (mode == 1'b0) begin
         // Encode: pass the bit through and divide m(x)*x^n by g(x).
         fb = data ^ syndrome[CHECK_BITS-1];
         if (bit_cnt + CHECK_BITS >= MAX_LEN) overrun = 1'b1;
         if (bit_cnt < MAX_LEN) word_copy[bit_cnt] = data;
         if (bit_cnt < 63) bit_cnt++;
         syndrome = {syndrome[CHECK_BITS-2:0], 1'b0} ^ (fb ? gen_taps : '0);
         item = '{code_bit: data, last_out: 1'b0, corrected: 1'b0, failed: overrun};
         expected_bits_q = {expected_bits_q, item};
         if (last) begin
            for (int k = CHECK_BITS - 1; k >= 0; k--) begin
               item = '{code_bit: syndrome[k], last_out: (k == 0), corrected: 1'b0,
                        failed: overrun};
               expected_bits_q = {expected_bits_q, item};
            end
            clear_word();
         end
      end else begin
         // Decode: store the bit and fold it into the syndrome.
         if (bit_cnt >= MAX_LEN) overrun = 1'b1;
         else word_copy[bit_cnt] = data;
         if (bit_cnt < 63) bit_cnt++;
         wide = {syndrome, data};
         if (wide[CHECK_BITS]) wide ^= {1'b1, gen_taps};
         syndrome = wide[CHECK_BITS-1:0];
         if (last) begin
            len  = (bit_cnt < MAX_LEN) ? bit_cnt : MAX_LEN;
            corr = 1'b0;
            fail = overrun;
            flip = -1;
            // Single-error search; the earliest matching position wins.
            if (syndrome != '0 && !overrun) begin
               err_syn = CHECK_BITS'(1);
               for (int p = len - 1; p >= 0; p--) begin
                  if (err_syn == syndrome) flip = p;
                  wide = {err_syn, 1'b0};
                  if (wide[CHECK_BITS]) wide ^= {1'b1, gen_taps};
                  err_syn = wide[CHECK_BITS-1:0];
               end
               if (flip >= 0) corr = 1'b1;
               else fail = 1'b1;
            end
            for (int i = 0; i < len; i++) begin
               item = '{code_bit: word_copy[i] ^ (i == flip), last_out: (i == len - 1),
                        corrected: corr, failed: fail};
               expected_bits_q = {expected_bits_q, item};
            end
            clear_word();
         end
      end
   endtask

   // Compare results, then apply requests and register writes of this edge.
   always @(posedge clock) begin
      code_bit_type exp_bit;
      if (reset) begin
         gen_taps = TAPS_RESET;
         foreach (word_copy[i]) word_copy[i] = 1'b0;
         clear_word();
         expected_bits_q.delete();
         errors    = 0;
         checked   = 0;
         corr_seen = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_bits_q.size() == 0) begin
               report_mismatch("result bit with nothing expected");
            end else begin
               exp_bit = expected_bits_q.pop_front();
               checked++;
               if (exp_bit.corrected) corr_seen++;
               if (rsp_code_bit !== exp_bit.code_bit)
                  report_mismatch($sformatf("code_bit %b, expected %b",
                                            rsp_code_bit, exp_bit.code_bit));
               if (rsp_last_out !== exp_bit.last_out)
                  report_mismatch($sformatf("last_out %b, expected %b",
                                            rsp_last_out, exp_bit.last_out));
               if (rsp_corrected !== exp_bit.corrected)
                  report_mismatch($sformatf("corrected %b, expected %b",
                                            rsp_corrected, exp_bit.corrected));
               if (rsp_failed !== exp_bit.failed)
                  report_mismatch($sformatf("failed %b, expected %b",
                                            rsp_failed, exp_bit.failed));
            end
         end
         if (start && !busy) predict_request(req_mode, req_data_bit, req_last_in);
         if (csr_valid && csr_ready) gen_taps = csr_generator_taps;
      end
      pending_count <= expected_bits_q.size();
   end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the cyclic code unit with directed and random encode, decode and
// mixed words under several generator settings, in bursts with random gaps.
// A checker beside the block predicts and compares every result bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import cce_pkg::*;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_mode;
   logic             req_data_bit;
   logic             req_last_in;
   logic             rsp_strobe;
   logic             rsp_code_bit;
   logic             rsp_last_out;
   logic             rsp_corrected;
   logic             rsp_failed;
   logic             csr_valid;
   logic             csr_ready;
   logic [TAP_W-1:0] csr_generator_taps;

   int               mismatch_count;
   int               pending_count;
   int               checked_count;
   int               corrected_count;

   // Stimulus bookkeeping.
   logic [TAP_W-1:0] cur_taps;
   int               burst_left;
   int               bits_sent;
   int               words_sent;
   int               settings_used;
   logic             word_bits[$];
   logic             word_modes[$];

   cyclic_code_encoder_corrector i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_data_bit       (req_data_bit),
      .req_last_in        (req_last_in),
      .rsp_strobe         (rsp_strobe),
      .rsp_code_bit       (rsp_code_bit),
      .rsp_last_out       (rsp_last_out),
      .rsp_corrected      (rsp_corrected),
      .rsp_failed         (rsp_failed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_generator_taps (csr_generator_taps)
   );

   cce_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_data_bit       (req_data_bit),
      .req_last_in        (req_last_in),
      .rsp_strobe         (rsp_strobe),
      .rsp_code_bit       (rsp_code_bit),
      .rsp_last_out       (rsp_last_out),
      .rsp_corrected      (rsp_corrected),
      .rsp_failed         (rsp_failed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_generator_taps (csr_generator_taps),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count),
      .corrected_count    (corrected_count)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit.
   initial begin
      #2_000_000;
      $display("Timeout: the run did not complete in time.");
      $display("== FAIL ==");
      $finish;
   end

   // Idle the sender for a random gap and pick the next burst length.
   task automatic pause_sender();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
   endtask

   // Present one request and hold it until the block takes it.
   task automatic send_bit(input logic m, input logic d, input logic l);
      if (burst_left <= 0) pause_sender();
      @(negedge clock);
      start        <= 1'b1;
      req_mode     <= m;
      req_data_bit <= d;
      req_last_in  <= l;
      do @(posedge clock); while (busy);
      burst_left--;
      bits_sent++;
   endtask

   task automatic send_word();
      for (int i = 0; i < word_bits.size(); i++)
         send_bit(word_modes[i], word_bits[i], i == word_bits.size() - 1);
      words_sent++;
   endtask

   task automatic push_bit(input logic m, input logic d);
      word_bits  = {word_bits, d};
      word_modes = {word_modes, m};
   endtask

   // Encode word; with mixed set each bit picks its own mode.
   task automatic build_encode_word(input int len, input logic mixed);
      word_bits.delete();
      word_modes.delete();
      for (int i = 0; i < len; i++)
         push_bit(mixed ? 1'($urandom_range(0, 1)) : 1'b0, 1'($urandom_range(0, 1)));
   endtask

   // Decode word: a codeword under the current taps where the length allows,
   // with no, one or two bits flipped, or a fully random word (kind 3).
   task automatic build_decode_word(input int len, input int err_kind);
      logic [CHECK_BITS-1:0] chk;
      logic                  fb;
      logic                  d;
      int                    pos;
      word_bits.delete();
      word_modes.delete();
      if (len > CHECK_BITS && len <= MAX_LEN && err_kind != 3) begin
         chk = '0;
         for (int i = 0; i < len - CHECK_BITS; i++) begin
            d   = 1'($urandom_range(0, 1));
            fb  = d ^ chk[CHECK_BITS-1];
            chk = {chk[CHECK_BITS-2:0], 1'b0} ^ (fb ? cur_taps : '0);
            push_bit(1'b1, d);
         end
         for (int k = CHECK_BITS - 1; k >= 0; k--) push_bit(1'b1, chk[k]);
      end else begin
         for (int i = 0; i < len; i++) push_bit(1'b1, 1'($urandom_range(0, 1)));
      end
      for (int e = 0; e < err_kind && err_kind < 3; e++) begin
         pos = $urandom_range(0, len - 1);
         word_bits[pos] = ~word_bits[pos];
      end
   endtask

   // Stop sending and let every expected bit and any search finish.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (2 * MAX_LEN + 10) @(posedge clock);
   endtask

   task automatic write_taps(input logic [TAP_W-1:0] value);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_generator_taps <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_taps = value;
      settings_used++;
   endtask

   // Random words until the phase has sent its share of request bits.
   task automatic random_phase(input int target_bits);
      int first_bit;
      int pick;
      int len;
      first_bit = bits_sent;
      while (bits_sent - first_bit < target_bits) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(27, 33)
                                              : $urandom_range(1, MAX_LEN - CHECK_BITS);
            build_encode_word(len, 1'b0);
         end else if (pick < 88) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) len = $urandom_range(1, CHECK_BITS);
            else if (pick == 1) len = $urandom_range(MAX_LEN + 1, MAX_LEN + 5);
            else len = $urandom_range(CHECK_BITS + 1, MAX_LEN);
            build_decode_word(len, $urandom_range(0, 3));
         end else begin
            build_encode_word($urandom_range(1, 20), 1'b1);
         end
         send_word();
      end
      drain();
   endtask

   // Main sequence.
   initial begin
      logic [TAP_W-1:0] taps_plan[6];
      start              = 1'b0;
      req_mode           = 1'b0;
      req_data_bit       = 1'b0;
      req_last_in        = 1'b0;
      csr_valid          = 1'b0;
      csr_generator_taps = '0;
      reset              = 1'b1;
      cur_taps           = TAPS_RESET;
      burst_left         = 0;
      bits_sent          = 0;
      words_sent         = 0;
      settings_used      = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset generator.
      word_bits.delete(); word_modes.delete();
      push_bit(1'b0, 1'b1);
      send_word();
      word_bits.delete(); word_modes.delete();
      push_bit(1'b0, 1'b0);
      send_word();
      // A lone decoded one is a correctable error; a lone zero is clean.
      word_bits.delete(); word_modes.delete();
      push_bit(1'b1, 1'b1);
      send_word();
      word_bits.delete(); word_modes.delete();
      push_bit(1'b1, 1'b0);
      send_word();
      build_decode_word(8, 1);
      send_word();
      build_decode_word(7, 0);
      send_word();
      // Mixed modes: encode bits pass out; the final bit's mode picks check bits or the stored word.
      word_bits.delete(); word_modes.delete();
      push_bit(1'b0, 1'b1);
      push_bit(1'b1, 1'b0);
      send_word();
      word_bits.delete(); word_modes.delete();
      push_bit(1'b1, 1'b1);
      push_bit(1'b0, 1'b1);
      send_word();
      drain();

      // Random phases over the extremes and random generators.
      taps_plan = '{5'd0, 5'd31, TAPS_RESET, 5'd0, 5'd0, 5'd0};
      for (int i = 3; i < 6; i++) taps_plan[i] = TAP_W'($urandom_range(0, 31));
      foreach (taps_plan[i]) begin
         write_taps(taps_plan[i]);
         random_phase(45);
      end

      $display("Covered %0d words (%0d request bits) under %0d generator settings.",
               words_sent, bits_sent, settings_used);
      $display("Checked %0d result bits, %0d of them in corrected words.",
               checked_count, corrected_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         if (pending_count != 0)
            $display("%0d expected result bits never arrived.", pending_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/cce_pkg.sv
src/cce_ram.sv
src/cce_queue.sv
src/cce_front.sv
src/cce_back.sv
src/cyclic_code_encoder_corrector.sv
tb/cce_checker.sv
tb/tb_top.sv
